### design/tsoc_pkg.sv
// tsoc_pkg: shared types and constants for the timestamp order checker.
// Request and status codes, table sizes, item entry and update records.
// No dependencies.
`timescale 1ns / 1ps

package tsoc_pkg;

    localparam int TXN_AW     = 4;
    localparam int ITEM_AW    = 8;
    localparam int TXN_SLOTS  = 1 << TXN_AW;
    localparam int ITEM_SLOTS = 1 << ITEM_AW;
    localparam int STAMP_W    = 64;
    localparam int DATA_W     = 32;

    typedef enum logic [2:0] {
        KIND_BEGIN  = 3'd0,
        KIND_READ   = 3'd1,
        KIND_WRITE  = 3'd2,
        KIND_COMMIT = 3'd3,
        KIND_ABORT  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_TXN   = 3'd1,
        ST_NO_ITEM  = 3'd2,
        ST_CONFLICT = 3'd3,
        ST_ALREADY  = 3'd4
    } t_status;

    typedef struct packed {
        logic [STAMP_W-1:0] read_stamp;
        logic [STAMP_W-1:0] write_stamp;
        logic [DATA_W-1:0]  value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // state changes decided for one request
    typedef struct packed {
        logic   txn_set;
        logic   txn_clr;
        logic   item_we;
        logic   present_set;
        t_entry entry;
    } t_update;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  read_data;
    } t_result;

endpackage

### design/tsoc_ram.sv
// tsoc_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module tsoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### design/tsoc_decide.sv
// tsoc_decide: timestamp-ordering decision for one request.
// Pure combinational; uses the types of tsoc_pkg.
`timescale 1ns / 1ps

module tsoc_decide (
    input  tsoc_pkg::t_kind                  i_kind,
    input  logic [tsoc_pkg::DATA_W-1:0]      i_wdata,
    input  logic                             i_txn_active,
    input  logic [tsoc_pkg::STAMP_W-1:0]     i_txn_start,
    input  logic                             i_present,
    input  tsoc_pkg::t_entry                 i_entry,
    output tsoc_pkg::t_update                o_upd,
    output tsoc_pkg::t_result                o_res
);
    import tsoc_pkg::*;

    t_entry w_cur;
    logic   w_lt_rs;
    logic   w_lt_ws;

    // an absent item is taken as all zero
    assign w_cur   = i_present ? i_entry : '0;
    assign w_lt_rs = i_txn_start < w_cur.read_stamp;
    assign w_lt_ws = i_txn_start < w_cur.write_stamp;

    always_comb begin
        o_upd           = '0;
        o_upd.entry     = w_cur;
        o_res.status    = ST_OK;
        o_res.read_data = '0;
        unique case (i_kind)
            KIND_BEGIN: begin
                if (i_txn_active) begin
                    o_res.status = ST_ALREADY;
                end else begin
                    o_upd.txn_set = 1'b1;
                end
            end
            KIND_COMMIT, KIND_ABORT: begin
                if (!i_txn_active) begin
                    o_res.status = ST_NO_TXN;
                end else begin
                    o_upd.txn_clr = 1'b1;
                end
            end
            KIND_READ: begin
                priority if (!i_txn_active) begin
                    o_res.status = ST_NO_TXN;
                end else if (!i_present) begin
                    o_res.status = ST_NO_ITEM;
                end else if (w_lt_ws) begin
                    o_upd.txn_clr = 1'b1;
                    o_res.status  = ST_CONFLICT;
                end else begin
                    o_upd.item_we = 1'b1;
                    if (!w_lt_rs) begin
                        o_upd.entry.read_stamp = i_txn_start;
                    end
                    o_res.read_data = w_cur.value;
                end
            end
            KIND_WRITE: begin
                if (!i_txn_active) begin
                    o_res.status = ST_NO_TXN;
                end else begin
                    o_upd.present_set = 1'b1;
                    o_upd.item_we     = 1'b1;
                    if (w_lt_rs || w_lt_ws) begin
                        o_upd.txn_clr = 1'b1;
                        o_res.status  = ST_CONFLICT;
                    end else begin
                        o_upd.entry.write_stamp = i_txn_start;
                        o_upd.entry.value       = i_wdata;
                    end
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase
    end

endmodule

### design/timestamp_order_checker_unit.sv
// Usage
// -----
// Timestamp-ordering checker over a 16-slot transaction table and a 256-entry
// item table. Requests arrive on the slave stream (tuser = kind, tdata =
// txn_slot, item_slot, start_stamp, write_data from the low bit up); each
// request returns exactly one result on the master stream (tuser = status,
// tdata = read_data).
// Pipeline: the request register and the item RAM read load at the accept
// edge, and the decision is then registered into the output register that
// drives o_m_tvalid. Throughput: one request per cycle while the receiver
// does not stall. The only loop is the item RAM read-modify-write; a write
// lands at the edge where the next request's read is issued, and a
// one-entry bypass supplies the fresh entry.
// Reset clears the active bits, the item present bits and all valid flags
// at once; no clearing pass is needed and i_s_tvalid may be asserted in the
// first cycle after reset.
// When the receiver stalls, the result stays in the output register, the
// decision stage holds its request and o_s_tready drops once both are full.
// Depends on tsoc_pkg, tsoc_ram and tsoc_decide.
`timescale 1ns / 1ps

module timestamp_order_checker_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // txn_slot[3:0], item_slot[11:4], start_stamp[75:12], write_data[107:76]
    input  logic [111:0] i_s_tdata,
    // kind[2:0]
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // read_data[31:0]
    output logic [31:0]  o_m_tdata,
    // status[2:0]
    output logic [2:0]   o_m_tuser
);
    import tsoc_pkg::*;

    // decision stage
    logic                r_s1_valid;
    t_kind               r_kind;
    logic [TXN_AW-1:0]   r_txn;
    logic [ITEM_AW-1:0]  r_item;
    logic [STAMP_W-1:0]  r_stamp;
    logic [DATA_W-1:0]   r_wdata;

    // transaction and present tables
    logic [TXN_SLOTS-1:0]  r_txn_active;
    logic [STAMP_W-1:0]    r_txn_start [TXN_SLOTS];
    logic [ITEM_SLOTS-1:0] r_present;

    // bypass of the write issued at the accept edge
    logic               r_fwd_valid;
    logic [ITEM_AW-1:0] r_fwd_addr;
    t_entry             r_fwd_entry;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [DATA_W-1:0]  r_out_data;

    logic               w_adv;
    logic               w_fire;
    logic               w_acc;
    logic               w_we;
    logic [ENTRY_W-1:0] w_ram_rd;
    t_entry             w_entry;
    t_update            w_upd;
    t_result            w_res;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_fire     = r_s1_valid && w_adv;
    assign o_s_tready = !r_s1_valid || w_adv;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_we       = w_fire && w_upd.item_we;

    tsoc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ITEM_SLOTS)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_item),
        .i_wdata (w_upd.entry),
        .i_re    (w_acc),
        .i_raddr (i_s_tdata[11:4]),
        .o_rdata (w_ram_rd)
    );

    assign w_entry = (r_fwd_valid && r_fwd_addr == r_item) ? r_fwd_entry : t_entry'(w_ram_rd);

    tsoc_decide u_decide (
        .i_kind       (r_kind),
        .i_wdata      (r_wdata),
        .i_txn_active (r_txn_active[r_txn]),
        .i_txn_start  (r_txn_start[r_txn]),
        .i_present    (r_present[r_item]),
        .i_entry      (w_entry),
        .o_upd        (w_upd),
        .o_res        (w_res)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_txn_active <= '0;
            r_present    <= '0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_acc) begin
                r_fwd_valid <= w_we;
            end
            if (w_fire && w_upd.txn_set) begin
                r_txn_active[r_txn] <= 1'b1;
            end
            if (w_fire && w_upd.txn_clr) begin
                r_txn_active[r_txn] <= 1'b0;
            end
            if (w_fire && w_upd.present_set) begin
                r_present[r_item] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind      <= t_kind'(i_s_tuser);
            r_txn       <= i_s_tdata[3:0];
            r_item      <= i_s_tdata[11:4];
            r_stamp     <= i_s_tdata[75:12];
            r_wdata     <= i_s_tdata[107:76];
            r_fwd_addr  <= r_item;
            r_fwd_entry <= w_upd.entry;
        end
        if (w_fire && w_upd.txn_set) begin
            r_txn_start[r_txn] <= r_stamp;
        end
        if (w_fire) begin
            r_out_status <= w_res.status;
            r_out_data   <= w_res.read_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

`ifndef SYNTH
    // data is only returned by a granted read
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data != '0) |-> (r_out_status == ST_OK))
        else $error("read data with non-ok status");

    // the item RAM is written only when a decision is taken
    a_we_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_s1_valid && w_adv))
        else $error("item write without a decision");

    // a conflict leaves the transaction inactive
    a_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res.status == ST_CONFLICT) |=> !r_txn_active[$past(r_txn)])
        else $error("conflict left transaction active");
`endif

endmodule
